### hdl/ruci_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ruci_pkg
// shared types, widths and helpers for the unit cylinder intersection pipeline
// ----------------------------------------------------------------------------
package ruci_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int A_W         = 64;                  // a, b, c magnitudes, Q.2F
	localparam int D_W         = 2 * A_W;             // discriminant, Q.4F
	localparam int S_W         = D_W / 2;             // square root, Q.2F
	localparam int NUM_W       = S_W + 1;             // root numerator
	localparam int Q_W         = 32;                  // root quotient, Q.F
	localparam int SQRT_STAGES = S_W;
	localparam int DIV_STAGES  = Q_W;
	localparam int DIV_W       = (NUM_W + FRAC_BITS > A_W + Q_W - 1) ?
	                             (NUM_W + FRAC_BITS) : (A_W + Q_W - 1);
	localparam logic [A_W-1:0] ONE_2F = A_W'(1) << (2 * FRAC_BITS);

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic [30:0]        max_distance;
		logic               from_surface;
	} ray_t;

	typedef struct packed {
		logic        hit;
		logic [30:0] distance;
	} result_t;

	// context that rides alongside the square root
	typedef struct packed {
		logic [A_W-1:0]     bmag;
		logic               bneg;
		logic [A_W-1:0]     a;
		logic [30:0]        maxd;
		logic signed [31:0] dz;
		logic signed [31:0] oz;
		logic               nohit;
	} sqrt_side_t;

	// context that rides alongside the dividers
	typedef struct packed {
		logic               en1;
		logic               en2;
		logic [30:0]        maxd;
		logic signed [31:0] dz;
		logic signed [31:0] oz;
	} div_ctx_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic [31:0] u;
		u = v;
		return v[31] ? (~u + 32'd1) : u;
	endfunction

endpackage
`default_nettype wire

### hdl/ray_unit_cylinder_intersect.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_unit_cylinder_intersect
// ray test against the open unit cylinder wall, heights strictly 0 to 1
// ----------------------------------------------------------------------------
// Fully pipelined: busy is always low, so a ray is taken on every cycle that
// start is high, and each ray gives one result strobed on done, in arrival
// order, after s1 to s6, the 64-stage square root of the 128-bit discriminant
// (one root bit a stage), s7, the 32-stage dividers for the two roots, which
// run side by side, s8, s9 and the output register. The receiver cannot hold
// results off and none is needed: nothing ever backs up. On a miss distance
// returns max_distance unchanged.
// ----------------------------------------------------------------------------
module ray_unit_cylinder_intersect import ruci_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire ray_t ray,
	output logic      done,
	output result_t   result
);

	// never stalls
	assign busy = 1'b0;

	// ---- s1: squares and cross products of the components
	logic               vld_s1;
	logic [63:0]        dxx_s1, dyy_s1, oxx_s1, oyy_s1, m1_s1, m2_s1;
	logic               neg1_s1, neg2_s1, surf_s1;
	logic [30:0]        maxd_s1;
	logic signed [31:0] dz_s1, oz_s1;
	logic [31:0]        dxm, dym, oxm, oym;

	always_comb begin
		dxm = mag32(ray.dir_x);
		dym = mag32(ray.dir_y);
		oxm = mag32(ray.origin_x);
		oym = mag32(ray.origin_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		dxx_s1  <= 64'(dxm) * 64'(dxm);
		dyy_s1  <= 64'(dym) * 64'(dym);
		oxx_s1  <= 64'(oxm) * 64'(oxm);
		oyy_s1  <= 64'(oym) * 64'(oym);
		m1_s1   <= 64'(dxm) * 64'(oxm);
		m2_s1   <= 64'(dym) * 64'(oym);
		// a product is negative only if the signs differ and neither is zero
		neg1_s1 <= (ray.dir_x[31] ^ ray.origin_x[31]) && (ray.dir_x != 0)
		           && (ray.origin_x != 0);
		neg2_s1 <= (ray.dir_y[31] ^ ray.origin_y[31]) && (ray.dir_y != 0)
		           && (ray.origin_y != 0);
		surf_s1 <= ray.from_surface;
		maxd_s1 <= ray.max_distance;
		dz_s1   <= ray.dir_z;
		oz_s1   <= ray.origin_z;
	end

	// ---- s2: a, r^2 and signed b
	logic               vld_s2, bneg_s2, surf_s2;
	logic [63:0]        a_s2, r2_s2, bmag_s2;
	logic [30:0]        maxd_s2;
	logic signed [31:0] dz_s2, oz_s2;
	logic [63:0]        bmag_c;
	logic               bneg_c;

	always_comb begin
		priority if (neg1_s1 == neg2_s1) begin
			bmag_c = m1_s1 + m2_s1;
			bneg_c = neg1_s1;
		end else if (m1_s1 >= m2_s1) begin
			bmag_c = m1_s1 - m2_s1;
			bneg_c = neg1_s1;
		end else begin
			bmag_c = m2_s1 - m1_s1;
			bneg_c = neg2_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		a_s2    <= dxx_s1 + dyy_s1;
		r2_s2   <= oxx_s1 + oyy_s1;
		bmag_s2 <= bmag_c;
		bneg_s2 <= bneg_c;
		surf_s2 <= surf_s1;
		maxd_s2 <= maxd_s1;
		dz_s2   <= dz_s1;
		oz_s2   <= oz_s1;
	end

	// ---- s3: c = r^2 - 1 as sign and magnitude, zero for a surface ray
	logic               vld_s3, bneg_s3, cpos_s3, azero_s3;
	logic [63:0]        a_s3, bmag_s3, cmag_s3;
	logic [30:0]        maxd_s3;
	logic signed [31:0] dz_s3, oz_s3;
	logic [63:0]        cmag_c;
	logic               cpos_c;

	always_comb begin
		priority if (surf_s2) begin
			cpos_c = 1'b0;
			cmag_c = '0;
		end else if (r2_s2 >= ONE_2F) begin
			cpos_c = 1'b1;
			cmag_c = r2_s2 - ONE_2F;
		end else begin
			cpos_c = 1'b0;
			cmag_c = ONE_2F - r2_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		a_s3     <= a_s2;
		azero_s3 <= (a_s2 == 0);
		bmag_s3  <= bmag_s2;
		bneg_s3  <= bneg_s2;
		cmag_s3  <= cmag_c;
		cpos_s3  <= cpos_c;
		maxd_s3  <= maxd_s2;
		dz_s3    <= dz_s2;
		oz_s3    <= oz_s2;
	end

	// ---- s4: 32x32 partial products of b*b and a*c
	logic               vld_s4, bneg_s4, cpos_s4, azero_s4;
	logic [63:0]        a_s4, bmag_s4;
	logic [63:0]        bp00_s4, bp01_s4, bp11_s4;
	logic [63:0]        ap00_s4, ap01_s4, ap10_s4, ap11_s4;
	logic [30:0]        maxd_s4;
	logic signed [31:0] dz_s4, oz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else         vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		bp00_s4  <= 64'(bmag_s3[31:0])  * 64'(bmag_s3[31:0]);
		bp01_s4  <= 64'(bmag_s3[31:0])  * 64'(bmag_s3[63:32]);
		bp11_s4  <= 64'(bmag_s3[63:32]) * 64'(bmag_s3[63:32]);
		ap00_s4  <= 64'(a_s3[31:0])  * 64'(cmag_s3[31:0]);
		ap01_s4  <= 64'(a_s3[31:0])  * 64'(cmag_s3[63:32]);
		ap10_s4  <= 64'(a_s3[63:32]) * 64'(cmag_s3[31:0]);
		ap11_s4  <= 64'(a_s3[63:32]) * 64'(cmag_s3[63:32]);
		a_s4     <= a_s3;
		azero_s4 <= azero_s3;
		bmag_s4  <= bmag_s3;
		bneg_s4  <= bneg_s3;
		cpos_s4  <= cpos_s3;
		maxd_s4  <= maxd_s3;
		dz_s4    <= dz_s3;
		oz_s4    <= oz_s3;
	end

	// ---- s5: full 128-bit b*b and a*c
	logic               vld_s5, bneg_s5, cpos_s5, azero_s5;
	logic [63:0]        a_s5, bmag_s5;
	logic [D_W-1:0]     bb_s5, ac_s5;
	logic [30:0]        maxd_s5;
	logic signed [31:0] dz_s5, oz_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else         vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		bb_s5    <= {bp11_s4, bp00_s4} + (D_W'(bp01_s4) << 33);
		ac_s5    <= {ap11_s4, ap00_s4} + (D_W'(ap01_s4) << 32) + (D_W'(ap10_s4) << 32);
		a_s5     <= a_s4;
		azero_s5 <= azero_s4;
		bmag_s5  <= bmag_s4;
		bneg_s5  <= bneg_s4;
		cpos_s5  <= cpos_s4;
		maxd_s5  <= maxd_s4;
		dz_s5    <= dz_s4;
		oz_s5    <= oz_s4;
	end

	// ---- s6: discriminant and the early no-hit flag
	logic           vld_s6;
	logic [D_W-1:0] d_s6;
	sqrt_side_t     side_s6;
	logic [D_W-1:0] d_c;
	logic           dbad_c;

	always_comb begin
		if (cpos_s5) begin
			d_c    = bb_s5 - ac_s5;
			dbad_c = bb_s5 <= ac_s5;
		end else begin
			d_c    = bb_s5 + ac_s5;
			dbad_c = d_c == 0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else         vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		d_s6          <= d_c;
		side_s6.bmag  <= bmag_s5;
		side_s6.bneg  <= bneg_s5;
		side_s6.a     <= a_s5;
		side_s6.maxd  <= maxd_s5;
		side_s6.dz    <= dz_s5;
		side_s6.oz    <= oz_s5;
		side_s6.nohit <= azero_s5 | dbad_c;
	end

	// ---- square root of the discriminant
	logic           sq_vld;
	logic [S_W-1:0] sq_root;
	sqrt_side_t     sq_side;

	ruci_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s6),
		.rad      (d_s6),
		.in_side  (side_s6),
		.out_vld  (sq_vld),
		.root     (sq_root),
		.out_side (sq_side)
	);

	// ---- s7: numerators of the nearer and farther roots
	logic             vld_s7;
	logic [NUM_W-1:0] num1_s7, num2_s7;
	logic [A_W-1:0]   a_s7;
	div_ctx_t         ctx_s7;
	logic             s_gt_b;

	assign s_gt_b = sq_root > sq_side.bmag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else         vld_s7 <= sq_vld;
	end

	always_ff @(posedge clk) begin
		// nearer root -b - s is positive only for negative b with |b| > s
		num1_s7     <= NUM_W'(sq_side.bmag - sq_root);
		num2_s7     <= sq_side.bneg ? (NUM_W'(sq_side.bmag) + NUM_W'(sq_root))
		                            : NUM_W'(sq_root - sq_side.bmag);
		a_s7        <= sq_side.a;
		ctx_s7.en1  <= !sq_side.nohit && sq_side.bneg && (sq_side.bmag > sq_root);
		ctx_s7.en2  <= !sq_side.nohit && (sq_side.bneg || s_gt_b);
		ctx_s7.maxd <= sq_side.maxd;
		ctx_s7.dz   <= sq_side.dz;
		ctx_s7.oz   <= sq_side.oz;
	end

	// ---- two dividers run side by side, context waits in a delay line
	logic [Q_W-1:0] q1, q2;

	ruci_div u_div_near (
		.clk (clk),
		.num (num1_s7),
		.den (a_s7),
		.quo (q1)
	);

	ruci_div u_div_far (
		.clk (clk),
		.num (num2_s7),
		.den (a_s7),
		.quo (q2)
	);

	logic     dl_vld [1:DIV_STAGES];
	div_ctx_t dl_ctx [1:DIV_STAGES];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_delay
		logic     cur_vld;
		div_ctx_t cur_ctx;

		if (i == 0) begin : g_first
			assign cur_vld = vld_s7;
			assign cur_ctx = ctx_s7;
		end else begin : g_next
			assign cur_vld = dl_vld[i];
			assign cur_ctx = dl_ctx[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dl_vld[i+1] <= 1'b0;
			else         dl_vld[i+1] <= cur_vld;
		end

		always_ff @(posedge clk) begin
			dl_ctx[i+1] <= cur_ctx;
		end
	end

	div_ctx_t ctx_d;
	assign ctx_d = dl_ctx[DIV_STAGES];

	// ---- s8: distance window and lambda*dz
	logic               vld_s8, en1_s8, en2_s8, rng1_s8, rng2_s8;
	logic [Q_W-1:0]     q1_s8, q2_s8;
	logic signed [64:0] prod1_s8, prod2_s8;
	logic [30:0]        maxd_s8;
	logic signed [31:0] oz_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else         vld_s8 <= dl_vld[DIV_STAGES];
	end

	always_ff @(posedge clk) begin
		q1_s8    <= q1;
		q2_s8    <= q2;
		rng1_s8  <= (q1 > Q_W'(1)) && (q1 < Q_W'(ctx_d.maxd));
		rng2_s8  <= (q2 > Q_W'(1)) && (q2 < Q_W'(ctx_d.maxd));
		prod1_s8 <= $signed({1'b0, q1}) * ctx_d.dz;
		prod2_s8 <= $signed({1'b0, q2}) * ctx_d.dz;
		en1_s8   <= ctx_d.en1;
		en2_s8   <= ctx_d.en2;
		maxd_s8  <= ctx_d.maxd;
		oz_s8    <= ctx_d.oz;
	end

	// ---- s9: height test, 0 < h < 1 in Q.2F
	logic               vld_s9, ok1_s9, ok2_s9;
	logic [Q_W-1:0]     q1_s9, q2_s9;
	logic [30:0]        maxd_s9;
	logic signed [65:0] ozs, h1, h2;
	logic               hok1, hok2;

	always_comb begin
		ozs  = 66'(oz_s8) <<< FRAC_BITS;
		h1   = 66'(prod1_s8) + ozs;
		h2   = 66'(prod2_s8) + ozs;
		hok1 = !h1[65] && (h1 != 0) && (h1 < 66'(ONE_2F));
		hok2 = !h2[65] && (h2 != 0) && (h2 < 66'(ONE_2F));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s9 <= 1'b0;
		else         vld_s9 <= vld_s8;
	end

	always_ff @(posedge clk) begin
		ok1_s9  <= en1_s8 && rng1_s8 && hok1;
		ok2_s9  <= en2_s8 && rng2_s8 && hok2;
		q1_s9   <= q1_s8;
		q2_s9   <= q2_s8;
		maxd_s9 <= maxd_s8;
	end

	// ---- output: nearer root wins, otherwise farther, otherwise pass through
	logic    done_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= vld_s9;
	end

	always_ff @(posedge clk) begin
		result_q.hit <= ok1_s9 || ok2_s9;
		priority if (ok1_s9) result_q.distance <= q1_s9[30:0];
		else if (ok2_s9)     result_q.distance <= q2_s9[30:0];
		else                 result_q.distance <= maxd_s9;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

### hdl/ruci_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ruci_sqrt
// pipelined floor square root, one result bit per stage
// ----------------------------------------------------------------------------
module ruci_sqrt import ruci_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_vld,
	input  wire logic [D_W-1:0]   rad,
	input  wire sqrt_side_t       in_side,
	output logic                  out_vld,
	output logic [S_W-1:0]        root,
	output sqrt_side_t            out_side
);

	logic [D_W-1:0] rem_s  [1:SQRT_STAGES];
	logic [S_W-1:0] root_s [1:SQRT_STAGES];
	logic           vld_s  [1:SQRT_STAGES];
	sqrt_side_t     side_s [1:SQRT_STAGES];

	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
		localparam int K = S_W - 1 - i;
		logic [D_W-1:0] cur_rem;
		logic [S_W-1:0] cur_root;
		logic           cur_vld;
		sqrt_side_t     cur_side;
		logic [D_W-1:0] trial;
		logic           take;

		if (i == 0) begin : g_first
			assign cur_rem  = rad;
			assign cur_root = '0;
			assign cur_vld  = in_vld;
			assign cur_side = in_side;
		end else begin : g_next
			assign cur_rem  = rem_s[i];
			assign cur_root = root_s[i];
			assign cur_vld  = vld_s[i];
			assign cur_side = side_s[i];
		end

		// (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^2k
		always_comb begin
			trial = (D_W'(cur_root) << (K + 1)) | (D_W'(1) << (2 * K));
			take  = cur_rem >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i+1] <= 1'b0;
			else         vld_s[i+1] <= cur_vld;
		end

		always_ff @(posedge clk) begin
			rem_s[i+1]  <= take ? (cur_rem - trial) : cur_rem;
			root_s[i+1] <= cur_root | (S_W'(take) << K);
			side_s[i+1] <= cur_side;
		end
	end

	assign out_vld  = vld_s[SQRT_STAGES];
	assign root     = root_s[SQRT_STAGES];
	assign out_side = side_s[SQRT_STAGES];

endmodule
`default_nettype wire

### hdl/ruci_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ruci_div
// pipelined saturating divider: floor(num * 2^F / den), one quotient bit a stage
// ----------------------------------------------------------------------------
module ruci_div import ruci_pkg::*; (
	input  wire logic             clk,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [A_W-1:0]   den,
	output logic [Q_W-1:0]        quo
);

	logic [DIV_W-1:0] rem_s [1:DIV_STAGES];
	logic [A_W-1:0]   den_s [1:DIV_STAGES];
	logic [Q_W-1:0]   quo_s [1:DIV_STAGES];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		localparam int K = Q_W - 1 - i;
		logic [DIV_W-1:0] cur_rem;
		logic [A_W-1:0]   cur_den;
		logic [Q_W-1:0]   cur_quo;
		logic [DIV_W-1:0] trial;
		logic             take;

		if (i == 0) begin : g_first
			assign cur_rem = DIV_W'(num) << FRAC_BITS;
			assign cur_den = den;
			assign cur_quo = '0;
		end else begin : g_next
			assign cur_rem = rem_s[i];
			assign cur_den = den_s[i];
			assign cur_quo = quo_s[i];
		end

		always_comb begin
			trial = DIV_W'(cur_den) << K;
			take  = cur_rem >= trial;
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= take ? (cur_rem - trial) : cur_rem;
			den_s[i+1] <= cur_den;
			quo_s[i+1] <= cur_quo | (Q_W'(take) << K);
		end
	end

	assign quo = quo_s[DIV_STAGES];

endmodule
`default_nettype wire
